>>> hdl/rc5_pkg.sv
package rc5_pkg;

   // frame length and word sizes
   localparam int FRAME_BITS_DEF = 14;
   localparam int WORD_MAX_BITS  = 16;
   localparam int FRAME_WORD_W   = 14;
   localparam int TIME_W         = 16;
   localparam int CSR_DATA_W     = 16;
   localparam int CSR_INDEX_W    = 2;
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 32;

   // register reset values
   localparam logic [CSR_DATA_W-1:0] SHORT_MIN_RST = 16'd444;
   localparam logic [CSR_DATA_W-1:0] SHORT_MAX_RST = 16'd1333;
   localparam logic [CSR_DATA_W-1:0] LONG_MIN_RST  = 16'd1334;
   localparam logic [CSR_DATA_W-1:0] LONG_MAX_RST  = 16'd2222;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SHORT_MIN = 2'd0,
      REG_SHORT_MAX = 2'd1,
      REG_LONG_MIN  = 2'd2,
      REG_LONG_MAX  = 2'd3
   } csr_index_type;

   // manchester phase codes
   typedef enum logic [1:0] {
      PH_START_ONE  = 2'd0,
      PH_MID_ONE    = 2'd1,
      PH_MID_ZERO   = 2'd2,
      PH_START_ZERO = 2'd3
   } phase_type;

   // gap event codes, used as bit offsets into a phase table row
   typedef enum logic [2:0] {
      EV_SHORT_SPACE = 3'd0,
      EV_SHORT_PULSE = 3'd2,
      EV_LONG_SPACE  = 3'd4,
      EV_LONG_PULSE  = 3'd6
   } event_type;

   // packed transition table, one row per phase, two bits per event
   localparam logic [7:0] PHASE_TABLE [4] = '{8'h01, 8'h91, 8'h9B, 8'hFB};

   // classified gap handed from classifier to phase core
   typedef struct packed {
      logic      hit;
      event_type ev;
   } gap_class_type;

   // result fields, frame word in the lowest bits
   typedef struct packed {
      logic [5:0]              command_code;
      logic [4:0]              device_address;
      logic                    toggle_bit;
      logic                    field_bit;
      logic [FRAME_WORD_W-1:0] frame_word;
   } frame_type;

endpackage

>>> hdl/rc5_gap_classifier.sv
module rc5_gap_classifier
   import rc5_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   edge_rising,
   input  logic [TIME_W-1:0]      elapsed_us,
   output gap_class_type          gap_class
);

   logic [CSR_DATA_W-1:0] short_min_ff, short_min_in;
   logic [CSR_DATA_W-1:0] short_max_ff, short_max_in;
   logic [CSR_DATA_W-1:0] long_min_ff, long_min_in;
   logic [CSR_DATA_W-1:0] long_max_ff, long_max_in;
   logic                  short_hit;
   logic                  long_hit;

   // register write decode
   always_comb begin
      short_min_in = short_min_ff;
      short_max_in = short_max_ff;
      long_min_in  = long_min_ff;
      long_max_in  = long_max_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            REG_SHORT_MIN: short_min_in = csr_wdata;
            REG_SHORT_MAX: short_max_in = csr_wdata;
            REG_LONG_MIN:  long_min_in  = csr_wdata;
            REG_LONG_MAX:  long_max_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_min_ff <= SHORT_MIN_RST;
         short_max_ff <= SHORT_MAX_RST;
         long_min_ff  <= LONG_MIN_RST;
         long_max_ff  <= LONG_MAX_RST;
      end else begin
         short_min_ff <= short_min_in;
         short_max_ff <= short_max_in;
         long_min_ff  <= long_min_in;
         long_max_ff  <= long_max_in;
      end
   end

   // window compares, short window wins on overlap
   assign short_hit = (elapsed_us >= short_min_ff) && (elapsed_us <= short_max_ff);
   assign long_hit  = (elapsed_us >= long_min_ff) && (elapsed_us <= long_max_ff);

   always_comb begin
      gap_class.hit = short_hit || long_hit;
      if (short_hit) begin
         gap_class.ev = edge_rising ? EV_SHORT_PULSE : EV_SHORT_SPACE;
      end else begin
         gap_class.ev = edge_rising ? EV_LONG_PULSE : EV_LONG_SPACE;
      end
   end

endmodule

>>> hdl/rc5_phase_core.sv
module rc5_phase_core
   import rc5_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  gap_class_type gap_class,
   output logic          emit,
   output frame_type     frame
);

   localparam int CNT_W = $clog2(FRAME_BITS + 1);

   phase_type              phase_ff, phase_in;
   logic [FRAME_BITS-1:0]  shift_ff, shift_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [7:0]             table_row;
   logic [7:0]             row_shifted;
   phase_type              next_phase;
   logic [FRAME_BITS-1:0]  shift_step;
   logic [CNT_W-1:0]       count_step;
   logic [WORD_MAX_BITS-1:0] word_ext;
   logic                   frame_done;

   // table lookup for the next phase
   assign table_row   = PHASE_TABLE[phase_ff];
   assign row_shifted = table_row >> gap_class.ev;
   assign next_phase  = phase_type'(row_shifted[1:0]);

   // phase step, bit shift on entry to a mid state, restart at mid-one on a miss or a stuck phase
   always_comb begin
      phase_in   = phase_ff;
      shift_step = shift_ff;
      count_step = count_ff;
      if (!gap_class.hit || (next_phase == phase_ff)) begin
         phase_in   = PH_MID_ONE;
         shift_step = FRAME_BITS'(1);
         count_step = CNT_W'(1);
      end else begin
         phase_in = next_phase;
         if (next_phase == PH_MID_ZERO) begin
            shift_step = {shift_ff[FRAME_BITS-2:0], 1'b0};
            count_step = CNT_W'(count_ff + 1'b1);
         end else if (next_phase == PH_MID_ONE) begin
            shift_step = {shift_ff[FRAME_BITS-2:0], 1'b1};
            count_step = CNT_W'(count_ff + 1'b1);
         end
      end
   end

   // frame completion clears word and count, phase is kept
   assign frame_done = (count_step == CNT_W'(FRAME_BITS));

   always_comb begin
      shift_in = shift_step;
      count_in = count_step;
      if (frame_done) begin
         shift_in = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MID_ONE;
         shift_ff <= FRAME_BITS'(1);
         count_ff <= CNT_W'(1);
      end else if (accept) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
      end
   end

   // result fields at fixed positions
   assign word_ext = WORD_MAX_BITS'(shift_step);
   assign emit     = accept && frame_done;

   always_comb begin
      frame.frame_word     = word_ext[FRAME_WORD_W-1:0];
      frame.field_bit      = word_ext[12];
      frame.toggle_bit     = word_ext[11];
      frame.device_address = word_ext[10:6];
      frame.command_code   = word_ext[5:0];
   end

endmodule

>>> hdl/rc5_rsp_fifo.sv
module rc5_rsp_fifo
   import rc5_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  frame_type push_data,
   output logic      push_ready,
   output logic      pop_valid,
   input  logic      pop_ready,
   output frame_type pop_data
);

   localparam int DEPTH = 2;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_type        data_ff [DEPTH];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // two-entry queue parts the input side from the result side
   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = data_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/rc5_ir_frame_decoder.sv
// a frame result shows on rsp_tvalid in the cycle after the edge transaction that ends it
// throughput: one edge transaction per cycle while req_tready is high, set by the phase step loop
// results pass through a two-entry queue: req_tready drops only while both entries wait
// and rises again the cycle after a result transaction drains one
// reset is synchronous: phase mid-one, shift word and bit count one, windows at defaults
module rc5_ir_frame_decoder
   import rc5_pkg::*;
#(
   parameter int FRAME_BITS = FRAME_BITS_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] elapsed_us
   input  logic [0:0]             req_tuser,   // [0] edge_rising
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [13:0] frame_word, [14] field_bit,
                                               // [15] toggle_bit, [20:16] device_address,
                                               // [26:21] command_code, [31:27] zero
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   gap_class_type gap_class;
   logic          accept;
   logic          emit;
   frame_type     frame;
   frame_type     rsp_frame;

   assign accept = req_tvalid && req_tready;

   // gap windows and event code
   rc5_gap_classifier u_classifier (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .edge_rising (req_tuser[0]),
      .elapsed_us  (req_tdata[TIME_W-1:0]),
      .gap_class   (gap_class)
   );

   // manchester phase and bit assembly
   rc5_phase_core #(
      .FRAME_BITS (FRAME_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .gap_class (gap_class),
      .emit      (emit),
      .frame     (frame)
   );

   // result queue
   rc5_rsp_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (emit),
      .push_data  (frame),
      .push_ready (req_tready),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (rsp_frame)
   );

   assign rsp_tdata = RSP_TDATA_W'(rsp_frame);

endmodule

>>> hdl/rc5_checker.sv
module rc5_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // no result straight after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // field copies agree with the frame word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[14] == rsp_tdata[12]) && (rsp_tdata[15] == rsp_tdata[11])
         && (rsp_tdata[20:16] == rsp_tdata[10:6]) && (rsp_tdata[26:21] == rsp_tdata[5:0])
         && (rsp_tdata[31:27] == 5'd0))
      else $error("result fields disagree with frame word");

   // queue never blocks the input side while results drain
   assert property (@(posedge clock) disable iff (reset) rsp_tready |=> req_tready)
      else $error("input stalled while results drain");

endmodule

bind rc5_ir_frame_decoder rc5_checker u_checker (.*);
